/* hdl/sipq_pkg.sv */
// Shared types, constants and codes for the sorted-insert priority queue.
package sipq_pkg;

    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

/* hdl/sipq_if.sv */
// Channel interfaces for the request and result items of the priority queue.
interface sipq_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [31:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface sipq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic               was_empty;
    logic               dropped_full;

    modport source (output valid, out_value, was_empty, dropped_full, input ready);
    modport sink   (input valid, out_value, was_empty, dropped_full, output ready);
endinterface

/* hdl/sipq_ctrl.sv */
// Controller state machine: accepts an item, runs it once the result register is free.
module sipq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sipq_pkg::cmd_t    cmd
);

    sipq_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             exec_go;

    assign req_ready = (state_reg == sipq_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;

    // The result register must be empty, or draining this cycle, before a new result lands.
    assign exec_go = (state_reg == sipq_pkg::ST_EXEC) && (!out_valid_reg || rsp_ready);

    assign cmd.capture = req_valid && req_ready;
    assign cmd.execute = exec_go;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sipq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sipq_pkg::ST_EXEC;
                end
            end
            sipq_pkg::ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = sipq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sipq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sipq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/sipq_datapath.sv */
// Datapath: row of entry cells with parallel compares, occupancy and result register.
module sipq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sipq_pkg::cmd_t      cmd,
    input  logic [1:0]          action,
    input  logic signed [31:0]  value,
    output logic signed [31:0]  out_value,
    output logic                was_empty,
    output logic                dropped_full
);

    localparam int N = sipq_pkg::CAPACITY;
    localparam int W = sipq_pkg::OCC_W;

    logic signed [31:0] entry_reg [N];
    logic signed [31:0] entry_next [N];
    logic [W-1:0]       occ_reg, occ_next;

    sipq_pkg::action_t  act_reg;
    logic signed [31:0] val_reg;

    logic signed [31:0] res_value_reg, res_value_next;
    logic               res_empty_reg, res_empty_next;
    logic               res_full_reg, res_full_next;

    logic               is_full, is_empty;
    logic [N-1:0]       greater;   // live entry that is greater than the new value
    logic [N-1:0]       seen;      // a greater entry at this cell or below
    logic [N-1:0]       at_tail;

    assign is_full  = (occ_reg == W'(N));
    assign is_empty = (occ_reg == '0);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            greater[i] = (W'(i) < occ_reg) && (val_reg < entry_reg[i]);
            at_tail[i] = (occ_reg == W'(i));
        end
        for (int i = 0; i < N; i++)
        begin
            seen[i] = |(greater & ({N{1'b1}} >> (N - 1 - i)));
        end
    end

    // Cell update. Cells at or past the occupancy may take any value.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        occ_next       = occ_reg;
        res_value_next = '0;
        res_empty_next = 1'b0;
        res_full_next  = 1'b0;

        case (act_reg)
            sipq_pkg::ACT_APPEND,
            sipq_pkg::ACT_INSERT:
            begin
                if (is_full)
                begin
                    res_full_next = 1'b1;
                end
                else
                begin
                    occ_next = occ_reg + W'(1);
                    for (int i = 0; i < N; i++)
                    begin
                        if (act_reg == sipq_pkg::ACT_APPEND)
                        begin
                            if (at_tail[i])
                            begin
                                entry_next[i] = val_reg;
                            end
                        end
                        else if (i > 0 && seen[i-1])
                        begin
                            entry_next[i] = entry_reg[i-1];
                        end
                        else if (greater[i] || (!seen[N-1] && at_tail[i]))
                        begin
                            entry_next[i] = val_reg;
                        end
                    end
                end
            end
            sipq_pkg::ACT_REMOVE:
            begin
                if (is_empty)
                begin
                    res_value_next = sipq_pkg::EMPTY_VALUE;
                    res_empty_next = 1'b1;
                end
                else
                begin
                    res_value_next = entry_reg[0];
                    occ_next       = occ_reg - W'(1);
                    for (int i = 0; i < N - 1; i++)
                    begin
                        entry_next[i] = entry_reg[i+1];
                    end
                end
            end
            default:
            begin
                res_value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.execute)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= sipq_pkg::action_t'(action);
            val_reg <= value;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < N; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            res_value_reg <= res_value_next;
            res_empty_reg <= res_empty_next;
            res_full_reg  <= res_full_next;
        end
    end

    assign out_value    = res_value_reg;
    assign was_empty    = res_empty_reg;
    assign dropped_full = res_full_reg;

endmodule

/* hdl/sorted_insert_priority_queue.sv */
// Top level of the sorted-insert priority queue: controller plus cell datapath.
//
// The req channel carries one item per handshake: an action (append at tail,
// insert by priority, remove head) and a signed 32-bit value. Every item gives
// exactly one result item on the rsp channel: the removed head value (or -1
// with was_empty set when the queue had nothing), zero for appends and
// inserts, and dropped_full set when either met a full queue of 16 entries.
// An item is taken in the idle state and executed in the execute state, where
// all cells compare against the new value at once and shift in a single step.
// The result is registered in the output register when the item executes, and
// no new item is taken until the last one has been executed. A result waits in
// its output register while the receiver stalls; the next item is still
// accepted, but it is not executed until that result has been taken. Reset
// empties the queue and drops any pending result.
module sorted_insert_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    sipq_req_if.sink      req,
    sipq_rsp_if.source    rsp
);

    sipq_pkg::cmd_t cmd;

    sipq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    sipq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (req.action),
        .value        (req.value),
        .out_value    (rsp.out_value),
        .was_empty    (rsp.was_empty),
        .dropped_full (rsp.dropped_full)
    );

endmodule
